// ===== sv/signed_int_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define SITDA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter assertion failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define SITDA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter assertion failed");

`endif

// ===== sv/sitda_pkg.sv =====
// Types and constants for the integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package sitda_pkg;

    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level: converts one signed 32-bit integer into its decimal ASCII text.
//
// Usage: present a word on value and raise start while busy is low; the word
// is taken at that clock edge and busy rises. The block then extracts decimal
// digits least significant first with one shared 32x32 reciprocal multiplier:
// each digit takes a multiply step, then a quotient and remainder step. The
// text then leaves most significant first, one character per cycle on
// char_code with char_valid high for exactly one cycle; a negative number
// starts with a minus sign. last_char marks the final character. The receiver
// cannot stall the output, and each character must be taken in the cycle it
// is shown. busy falls in the cycle after the last character and a new word
// may then be started.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any conversion in progress without emitting further characters.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] value,
    output logic                    char_valid,
    output logic              [7:0] char_code,
    output logic                    last_char
);
    import sitda_pkg::*;
    `include "signed_int_to_decimal_ascii_macros.svh"

    state_t             state_reg, state_next;
    logic        [31:0] mag_reg, mag_next;
    logic        [63:0] prod_reg;
    logic               neg_reg, neg_next;
    logic   [IDX_W-1:0] idx_reg, idx_next;
    logic         [3:0] digits_reg [MAX_DIGITS];

    logic        [31:0] quot;
    logic        [31:0] quot_x10;
    logic         [3:0] rem;
    logic               accept;

    assign accept   = start && !busy;
    assign quot     = 32'(prod_reg[63:RECIP_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = 4'(mag_reg - quot_x10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= {32'b0, mag_reg} * {32'b0, RECIP_10};
        if (state_reg == ST_DIV)
        begin
            digits_reg[idx_reg] <= rem;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        busy       = 1'b1;
        char_valid = 1'b0;
        char_code  = CHAR_ZERO;
        last_char  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    neg_next   = value[31];
                    mag_next   = value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
                    idx_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mag_next = quot;
                // The write pointer stays on the top digit, where reading starts.
                if (quot == 32'd0 || idx_reg == IDX_W'(MAX_DIGITS - 1))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_SIGN:
            begin
                char_valid = 1'b1;
                char_code  = CHAR_MINUS;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                char_valid = 1'b1;
                char_code  = CHAR_ZERO + {4'b0, digits_reg[idx_reg]};
                last_char  = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SITDA_ASSERT_NOW(a_valid_while_busy, char_valid, busy)
    `SITDA_ASSERT_NOW(a_last_is_valid, last_char, char_valid)
    `SITDA_ASSERT_NEXT(a_sign_then_digit, char_valid && char_code == CHAR_MINUS,
        char_valid && char_code != CHAR_MINUS)
    `SITDA_ASSERT_NEXT(a_last_frees, char_valid && last_char, !busy)
    `SITDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !char_valid)

endmodule
`default_nettype wire
